// File: design/asplp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asplp_pkg: shared types and constants of the position line parser
// Event codes, the operation passed from the front end to the back end, and
// the field widths used on the ports.
// ----------------------------------------------------------------------------
package asplp_pkg;

  localparam int LINE_MAX_DEF = 32;
  localparam int STORED_CHARS = 6;

  localparam int LIMIT_W  = 14;
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 15;
  localparam int CNT_W    = 32;
  localparam int CFG_A_W  = 1;
  localparam int CFG_D_W  = 14;
  localparam int OUT_D_W  = 184;

  localparam logic [BYTE_W-1:0] CH_LINE_END = 8'd10;
  localparam logic [BYTE_W-1:0] CH_PLUS     = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS    = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_POINT    = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE     = 8'h39;

  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 14'd9999;
  localparam logic [BYTE_W-1:0]  MARKER_RST = 8'd35;

  localparam logic [CFG_A_W-1:0] CFG_POSITION_LIMIT = 1'b0;
  localparam logic [CFG_A_W-1:0] CFG_INVALID_MARKER = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_MARKER   = 3'd1,
    EV_FORMAT   = 3'd2,
    EV_VALID    = 3'd3,
    EV_OVERFLOW = 3'd4
  } evt_t;

  typedef struct packed {
    evt_t             evt;
    logic [POS_W-1:0] pos;
  } line_op_t;

endpackage
`default_nettype wire

// File: design/ascii_signed_position_line_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// Each accepted byte's line event is queued, then registered into the output beat.
// Throughput: one byte per cycle while in_tready is high; the front end classifies
// a byte per cycle and the back end retires one queued line event per cycle.
// A two-entry queue separates them, so output stalls reach in_tready after it fills.
// Reset (rst_n low, synchronous) clears counters, flags, line state and the
// queue, and restores the default limit and marker registers.
// ----------------------------------------------------------------------------
// ascii_signed_position_line_parser: signed position line parser top level
// Splits a byte stream into lines, decodes signed positions and keeps
// per-event counters, one result beat per received byte.
// ----------------------------------------------------------------------------
module ascii_signed_position_line_parser #(
  parameter int LINE_MAX = asplp_pkg::LINE_MAX_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [asplp_pkg::CFG_A_W-1:0]    cfg_addr,
  input  wire logic [asplp_pkg::CFG_D_W-1:0]    cfg_data,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,   // [7:0] rx_byte
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [14:0] position, [15] pos_ok, [47:16] packet_total,
  // [79:48] valid_total, [111:80] marker_total, [143:112] format_error_total,
  // [175:144] overflow_total, [178:176] line_event, [183:179] zero
  output logic [asplp_pkg::OUT_D_W-1:0]         out_tdata
);

  asplp_pkg::line_op_t fe_op, q_op;
  logic                byte_en, q_full, q_empty, q_pop;

  assign in_tready = !q_full;
  assign byte_en   = in_tvalid && in_tready;

  asplp_front #(.LINE_MAX(LINE_MAX)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .byte_en  (byte_en),
    .rx_byte  (in_tdata),
    .op       (fe_op)
  );

  asplp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (byte_en),
    .push_op (fe_op),
    .pop     (q_pop),
    .pop_op  (q_op),
    .full    (q_full),
    .empty   (q_empty)
  );

  asplp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_avail   (!q_empty),
    .op         (q_op),
    .op_take    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// File: design/asplp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asplp_front: byte intake and line classification
// Buffers the first characters of a line, tracks length and discard mode,
// and on each beat emits the line event and decoded position.
// ----------------------------------------------------------------------------
module asplp_front #(
  parameter int LINE_MAX = asplp_pkg::LINE_MAX_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [asplp_pkg::CFG_A_W-1:0]        cfg_addr,
  input  wire logic [asplp_pkg::CFG_D_W-1:0]        cfg_data,
  input  wire logic                                 byte_en,
  input  wire logic [asplp_pkg::BYTE_W-1:0]         rx_byte,
  output asplp_pkg::line_op_t                       op
);

  localparam int LEN_W = $clog2(LINE_MAX);
  localparam logic [LEN_W-1:0] LEN_LAST   = LEN_W'(LINE_MAX - 1);
  localparam logic [LEN_W-1:0] LEN_STORED = LEN_W'(asplp_pkg::STORED_CHARS);

  logic [asplp_pkg::LIMIT_W-1:0] limit_r;
  logic [asplp_pkg::BYTE_W-1:0]  marker_r;
  logic [asplp_pkg::BYTE_W-1:0]  chars_r [asplp_pkg::STORED_CHARS];
  logic [LEN_W-1:0]              len_r, len_nxt;
  logic                          discard_r, discard_nxt;

  logic                          is_end, store_en, fmt_ok;
  logic [3:0]                    dig1, dig2, dig4, dig5;
  logic [asplp_pkg::LIMIT_W-1:0] mag;
  asplp_pkg::evt_t               finish_evt;

  function automatic logic is_digit(input logic [asplp_pkg::BYTE_W-1:0] c);
    return (c >= asplp_pkg::CH_ZERO) && (c <= asplp_pkg::CH_NINE);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= asplp_pkg::LIMIT_RST;
      marker_r <= asplp_pkg::MARKER_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        asplp_pkg::CFG_POSITION_LIMIT: limit_r  <= cfg_data;
        asplp_pkg::CFG_INVALID_MARKER: marker_r <= cfg_data[asplp_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode of the stored line; only meaningful when a line end arrives.
  always_comb begin
    dig1 = chars_r[1][3:0];
    dig2 = chars_r[2][3:0];
    dig4 = chars_r[4][3:0];
    dig5 = chars_r[5][3:0];
    mag  = asplp_pkg::LIMIT_W'(dig1) * 14'd1000 + asplp_pkg::LIMIT_W'(dig2) * 14'd100
         + asplp_pkg::LIMIT_W'(dig4) * 14'd10 + asplp_pkg::LIMIT_W'(dig5);
    fmt_ok = (len_r == LEN_STORED)
          && ((chars_r[0] == asplp_pkg::CH_PLUS) || (chars_r[0] == asplp_pkg::CH_MINUS))
          && (chars_r[3] == asplp_pkg::CH_POINT)
          && is_digit(chars_r[1]) && is_digit(chars_r[2])
          && is_digit(chars_r[4]) && is_digit(chars_r[5]);
    priority if ((len_r == LEN_W'(1)) && (chars_r[0] == marker_r)) begin
      finish_evt = asplp_pkg::EV_MARKER;
    end else if (fmt_ok && (mag <= limit_r)) begin
      finish_evt = asplp_pkg::EV_VALID;
    end else begin
      finish_evt = asplp_pkg::EV_FORMAT;
    end
  end

  always_comb begin
    is_end      = (rx_byte == asplp_pkg::CH_LINE_END);
    len_nxt     = len_r;
    discard_nxt = discard_r;
    store_en    = 1'b0;
    op.evt      = asplp_pkg::EV_NONE;
    op.pos      = (chars_r[0] == asplp_pkg::CH_MINUS) ?
                  asplp_pkg::POS_W'(15'd0 - {1'b0, mag}) : {1'b0, mag};
    if (is_end) begin
      if (!discard_r && (len_r != '0)) begin
        op.evt = finish_evt;
      end
      len_nxt     = '0;
      discard_nxt = 1'b0;
    end else if (!discard_r) begin
      if (len_r >= LEN_LAST) begin
        op.evt      = asplp_pkg::EV_OVERFLOW;
        len_nxt     = '0;
        discard_nxt = 1'b1;
      end else begin
        store_en = (len_r < LEN_STORED);
        len_nxt  = len_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      discard_r <= 1'b0;
    end else if (byte_en) begin
      len_r     <= len_nxt;
      discard_r <= discard_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en && store_en) begin
      chars_r[len_r[2:0]] <= rx_byte;
    end
  end

endmodule
`default_nettype wire

// File: design/asplp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asplp_fifo: two-entry operation queue
// Decouples the front end from the back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module asplp_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire asplp_pkg::line_op_t push_op,
  input  wire logic          pop,
  output asplp_pkg::line_op_t pop_op,
  output logic               full,
  output logic               empty
);

  asplp_pkg::line_op_t mem_r [2];
  logic                wr_ptr_r, rd_ptr_r;
  logic [1:0]          count_r, count_nxt;

  assign full   = (count_r == 2'd2);
  assign empty  = (count_r == 2'd0);
  assign pop_op = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2) else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("pop from empty queue");

endmodule
`default_nettype wire

// File: design/asplp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asplp_back: result state, event counters and output register
// Applies each queued line event to the published state and presents one
// result beat per byte.
// ----------------------------------------------------------------------------
module asplp_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              op_avail,
  input  wire asplp_pkg::line_op_t               op,
  output logic                                   op_take,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [asplp_pkg::OUT_D_W-1:0]          out_tdata
);

  logic [asplp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                        vflag_r, vflag_nxt;
  logic [asplp_pkg::CNT_W-1:0] pkt_r, pkt_nxt, vld_r, vld_nxt, mkr_r, mkr_nxt;
  logic [asplp_pkg::CNT_W-1:0] fmt_r, fmt_nxt, ovf_r, ovf_nxt;
  logic                        out_valid_r;
  logic [asplp_pkg::OUT_D_W-1:0] out_data_r;

  // The output register frees up when its beat is taken in the same cycle.
  assign op_take    = op_avail && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    pos_nxt   = pos_r;
    vflag_nxt = vflag_r;
    pkt_nxt   = pkt_r;
    vld_nxt   = vld_r;
    mkr_nxt   = mkr_r;
    fmt_nxt   = fmt_r;
    ovf_nxt   = ovf_r;
    unique case (op.evt)
      asplp_pkg::EV_MARKER: begin
        pkt_nxt   = pkt_r + 32'd1;
        mkr_nxt   = mkr_r + 32'd1;
        vflag_nxt = 1'b0;
      end
      asplp_pkg::EV_FORMAT: begin
        fmt_nxt   = fmt_r + 32'd1;
        vflag_nxt = 1'b0;
      end
      asplp_pkg::EV_VALID: begin
        pos_nxt   = op.pos;
        pkt_nxt   = pkt_r + 32'd1;
        vld_nxt   = vld_r + 32'd1;
        vflag_nxt = 1'b1;
      end
      asplp_pkg::EV_OVERFLOW: begin
        ovf_nxt   = ovf_r + 32'd1;
        vflag_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      vflag_r     <= 1'b0;
      pkt_r       <= '0;
      vld_r       <= '0;
      mkr_r       <= '0;
      fmt_r       <= '0;
      ovf_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (op_take) begin
        pos_r   <= pos_nxt;
        vflag_r <= vflag_nxt;
        pkt_r   <= pkt_nxt;
        vld_r   <= vld_nxt;
        mkr_r   <= mkr_nxt;
        fmt_r   <= fmt_nxt;
        ovf_r   <= ovf_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_take) begin
      out_data_r <= {5'd0, op.evt, ovf_nxt, fmt_nxt, mkr_nxt, vld_nxt, pkt_nxt,
                     vflag_nxt, pos_nxt};
    end
  end

  a_valid_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r[178:176] == asplp_pkg::EV_VALID)) |-> out_data_r[15])
    else $error("valid position beat without valid flag");
  a_ovf_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r[178:176] == asplp_pkg::EV_OVERFLOW)) |-> !out_data_r[15])
    else $error("overflow beat with valid flag set");
  a_ovf_count: assert property (@(posedge clk) disable iff (!rst_n)
    (op_take && (op.evt == asplp_pkg::EV_OVERFLOW)) |=> (ovf_r == $past(ovf_r) + 32'd1))
    else $error("overflow counter did not advance");

endmodule
`default_nettype wire

// File: sim/ascii_signed_position_line_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_signed_position_line_parser_tb: self-checking bench of the line parser
// Feeds byte streams (directed lines, register sweeps, then random lines and
// noise) with random gaps on both stream sides. Each byte is also fed to a
// local model of the parser, and every result beat is checked against it.
// ----------------------------------------------------------------------------
module ascii_signed_position_line_parser_tb;
  import asplp_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int MAX_GAP          = 8;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int RANDOM_ITEMS     = 700;
  localparam int RANDOM_PHASES    = 4;

  typedef struct {
    logic [POS_W-1:0] position;
    logic             recog;
    logic [CNT_W-1:0] packets;
    logic [CNT_W-1:0] valids;
    logic [CNT_W-1:0] markers;
    logic [CNT_W-1:0] fmt_errs;
    logic [CNT_W-1:0] overflows;
    evt_t             line_evt;
  } line_status_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_A_W-1:0]   cfg_addr   = '0;
  logic [CFG_D_W-1:0]   cfg_data   = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_D_W-1:0]   out_tdata;

  // Local copy of the parser state and registers.
  logic [7:0]         line_buf [STORED_CHARS] = '{default: 8'd0};
  int                 line_len     = 0;
  bit                 drop_line    = 1'b0;
  logic [POS_W-1:0]   last_pos     = '0;
  bit                 pos_valid    = 1'b0;
  logic [CNT_W-1:0]   packet_cnt   = '0;
  logic [CNT_W-1:0]   valid_cnt    = '0;
  logic [CNT_W-1:0]   marker_cnt   = '0;
  logic [CNT_W-1:0]   format_cnt   = '0;
  logic [CNT_W-1:0]   overflow_cnt = '0;
  logic [LIMIT_W-1:0] pos_limit    = LIMIT_RST;
  logic [7:0]         marker_byte  = MARKER_RST;

  line_status_t status_q[$];
  int           mismatches = 0;
  int           failures   = 0;
  bit           steady     = 1'b0;
  int           stall_left = 0;
  int           sent_cnt   = 0;
  longint       cycle_cnt  = 0;

  ascii_signed_position_line_parser #(
    .LINE_MAX(LINE_MAX_DEF)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("ascii_signed_position_line_parser_tb: done, errors");
      $finish;
    end
  end

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Decodes the buffered line at its line end and updates the counters.
  function evt_t close_line();
    int mag;
    if (line_len == 1 && line_buf[0] == marker_byte) begin
      packet_cnt++;
      marker_cnt++;
      pos_valid = 1'b0;
      return EV_MARKER;
    end
    if (line_len != STORED_CHARS || !(line_buf[0] == CH_PLUS || line_buf[0] == CH_MINUS)
        || line_buf[3] != CH_POINT || !is_digit(line_buf[1]) || !is_digit(line_buf[2])
        || !is_digit(line_buf[4]) || !is_digit(line_buf[5])) begin
      format_cnt++;
      pos_valid = 1'b0;
      return EV_FORMAT;
    end
    mag = (int'(line_buf[1]) - int'(CH_ZERO)) * 1000 + (int'(line_buf[2]) - int'(CH_ZERO)) * 100
        + (int'(line_buf[4]) - int'(CH_ZERO)) * 10 + (int'(line_buf[5]) - int'(CH_ZERO));
    if (mag > int'(pos_limit)) begin
      format_cnt++;
      pos_valid = 1'b0;
      return EV_FORMAT;
    end
    last_pos = (line_buf[0] == CH_MINUS) ? POS_W'(-mag) : POS_W'(mag);
    packet_cnt++;
    valid_cnt++;
    pos_valid = 1'b1;
    return EV_VALID;
  endfunction

  function void predict_byte(logic [7:0] b);
    line_status_t s;
    evt_t ev;
    ev = EV_NONE;
    if (b == CH_LINE_END) begin
      if (!drop_line && line_len != 0) ev = close_line();
      line_len  = 0;
      drop_line = 1'b0;
    end else if (!drop_line) begin
      // A full buffer turns the line into an overflow and drops the byte.
      if (line_len >= LINE_MAX_DEF - 1) begin
        overflow_cnt++;
        pos_valid = 1'b0;
        line_len  = 0;
        drop_line = 1'b1;
        ev        = EV_OVERFLOW;
      end else begin
        if (line_len < STORED_CHARS) line_buf[line_len] = b;
        line_len++;
      end
    end
    s.position  = last_pos;
    s.recog     = pos_valid;
    s.packets   = packet_cnt;
    s.valids    = valid_cnt;
    s.markers   = marker_cnt;
    s.fmt_errs  = format_cnt;
    s.overflows = overflow_cnt;
    s.line_evt  = ev;
    status_q.push_back(s);
  endfunction

  function void check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (want !== got) begin
      failures++;
      mismatches++;
      if (mismatches <= SHOWN_MISMATCHES)
        $display("mismatch in %s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_beat
    line_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (status_q.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES) $display("result beat with nothing expected");
      end else begin
        want = status_q.pop_front();
        check_field("position", CNT_W'(want.position), CNT_W'(out_tdata[14:0]));
        check_field("pos_ok", CNT_W'(want.recog), CNT_W'(out_tdata[15]));
        check_field("packet_total", want.packets, out_tdata[47:16]);
        check_field("valid_total", want.valids, out_tdata[79:48]);
        check_field("marker_total", want.markers, out_tdata[111:80]);
        check_field("format_error_total", want.fmt_errs, out_tdata[143:112]);
        check_field("overflow_total", want.overflows, out_tdata[175:144]);
        check_field("line_event", CNT_W'(want.line_evt), CNT_W'(out_tdata[178:176]));
        check_field("pad", '0, CNT_W'(out_tdata[183:179]));
      end
    end
  end

  // After each accepted result beat the receiver draws a fresh stall length.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else if (out_tvalid && out_tready) begin
      stall_left = steady ? 0 : $urandom_range(0, MAX_GAP);
      out_tready <= (stall_left == 0);
    end else if (!out_tready) begin
      if (stall_left > 0) stall_left--;
      if (stall_left == 0) out_tready <= 1'b1;
    end
  end

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    predict_byte(b);
    sent_cnt++;
  endtask

  task automatic send_text(string body);
    for (int i = 0; i < body.len(); i++) send_byte(body[i]);
    send_byte(CH_LINE_END);
  endtask

  task automatic send_fill(int count, logic [7:0] b);
    repeat (count) send_byte(b);
  endtask

  // Lets every outstanding result drain so that the block is idle.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POSITION_LIMIT) pos_limit = value;
    else marker_byte = value[7:0];
    @(posedge clk);
  endtask

  task automatic test_line_formats();
    send_text("+12.34");
    send_text("-99.99");
    send_text("-00.00");
    send_text("#");
    send_byte(CH_LINE_END);
    send_text("##");
    send_text("+1.234");
    send_text("12.345");
    send_text("+12,34");
    send_text("+9:.00");
    send_text("-12.3/");
    send_text("+12.34x");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_LINE_END);
  endtask

  task automatic test_buffer_overflow();
    // The longest line that still fits, then one four bytes longer.
    send_fill(LINE_MAX_DEF - 1, CH_PLUS);
    send_byte(CH_LINE_END);
    send_fill(LINE_MAX_DEF + 3, 8'h7E);
    send_byte(CH_LINE_END);
    send_text("+05.07");
    send_fill(LINE_MAX_DEF, CH_ZERO);
    send_text("-43.21");
  endtask

  task automatic test_limit_register();
    settle();
    write_reg(CFG_POSITION_LIMIT, 14'd0);
    send_text("+00.00");
    send_text("-00.01");
    settle();
    write_reg(CFG_POSITION_LIMIT, 14'h3FFF);
    send_text("-99.99");
    settle();
    write_reg(CFG_POSITION_LIMIT, 14'd1234);
    send_text("+12.34");
    send_text("-12.35");
    settle();
    write_reg(CFG_POSITION_LIMIT, LIMIT_RST);
  endtask

  task automatic test_marker_register();
    settle();
    // A marker equal to line end can never match.
    write_reg(CFG_INVALID_MARKER, CFG_D_W'(CH_LINE_END));
    send_byte(CH_LINE_END);
    send_text("#");
    settle();
    write_reg(CFG_INVALID_MARKER, 14'd0);
    send_byte(8'h00);
    send_byte(CH_LINE_END);
    settle();
    write_reg(CFG_INVALID_MARKER, {6'h3F, 8'hFF});
    send_byte(8'hFF);
    send_byte(CH_LINE_END);
    settle();
    write_reg(CFG_INVALID_MARKER, CFG_D_W'(CH_PLUS));
    send_text("+");
    send_text("+12.34");
    settle();
    write_reg(CFG_INVALID_MARKER, MARKER_RST);
  endtask

  task automatic send_random_line();
    int kind;
    int mag;
    int len;
    logic [7:0] b;
    string txt;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      // Positions, often right at the limit, now and then with one byte spoiled.
      mag = ($urandom_range(0, 3) == 0) ? int'(pos_limit) + $urandom_range(0, 1)
                                        : $urandom_range(0, 9999);
      if (mag > 9999) mag = 9999;
      txt = $sformatf("%s%02d.%02d", $urandom_range(0, 1) ? "-" : "+", mag / 100, mag % 100);
      if ($urandom_range(0, 7) == 0) begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_LINE_END || b == 8'd0) b = 8'h7F;
        txt[$urandom_range(0, 5)] = b;
      end
      send_text(txt);
    end else if (kind < 65) begin
      send_byte(marker_byte);
      send_byte(CH_LINE_END);
    end else if (kind < 73) begin
      send_byte(CH_LINE_END);
    end else if (kind < 93) begin
      len = $urandom_range(1, 8);
      repeat (len) send_byte(8'($urandom_range(0, 255)));
      send_byte(CH_LINE_END);
    end else begin
      len = $urandom_range(LINE_MAX_DEF - 2, LINE_MAX_DEF + 8);
      repeat (len) begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_LINE_END) b = 8'h20;
        send_byte(b);
      end
      send_byte(CH_LINE_END);
    end
  endtask

  task automatic test_random_stream();
    int target;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        0: write_reg(CFG_POSITION_LIMIT, LIMIT_RST);
        1: write_reg(CFG_POSITION_LIMIT, CFG_D_W'($urandom_range(0, 9999)));
        2: write_reg(CFG_POSITION_LIMIT, 14'h3FFF);
        default: write_reg(CFG_POSITION_LIMIT, CFG_D_W'($urandom_range(0, 16383)));
      endcase
      case (phase)
        0: write_reg(CFG_INVALID_MARKER, MARKER_RST);
        2: write_reg(CFG_INVALID_MARKER, CFG_D_W'(CH_MINUS));
        default: write_reg(CFG_INVALID_MARKER, CFG_D_W'($urandom_range(0, 16383)));
      endcase
      // One phase runs with both sides never idling.
      steady = (phase == 2);
      target = sent_cnt + RANDOM_ITEMS / RANDOM_PHASES;
      while (sent_cnt < target) send_random_line();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_line_formats();
    test_buffer_overflow();
    test_limit_register();
    test_marker_register();
    test_random_stream();
    settle();
    repeat (6) @(posedge clk);
    failures += status_q.size();
    if (failures == 0) begin
      $display("ascii_signed_position_line_parser_tb: done, clean");
    end else begin
      $display("ascii_signed_position_line_parser_tb: done, errors");
    end
    $finish;
  end

endmodule
